FILE: rtl/cor_pkg.sv
// ----------------------------------------------------------------------------
// cor_pkg
// Shared widths, codes and types of the circle outline rasterizer.
// ----------------------------------------------------------------------------
package cor_pkg;

	localparam int COORD_BITS = 12;
	localparam int RAD_BITS   = 11;
	localparam int COLOR_BITS = 32;
	localparam int FRAME_BITS = 13;
	localparam int PIX_BITS   = 14;
	localparam int X_BITS     = 13;
	localparam int Y_BITS     = 12;
	localparam int ERR_BITS   = 16;
	localparam int STATUS_BITS = 2;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_STEP  = 1'b1;

	localparam logic [STATUS_BITS-1:0] STATUS_PIXEL    = 2'd0;
	localparam logic [STATUS_BITS-1:0] STATUS_STARTED  = 2'd1;
	localparam logic [STATUS_BITS-1:0] STATUS_REJECTED = 2'd2;
	localparam logic [STATUS_BITS-1:0] STATUS_IDLE     = 2'd3;

	localparam logic REG_FRAME_W = 1'b0;
	localparam logic REG_FRAME_H = 1'b1;

	localparam logic [FRAME_BITS-1:0] FRAME_W_RESET = 13'd800;
	localparam logic [FRAME_BITS-1:0] FRAME_H_RESET = 13'd600;

	typedef struct packed {
		logic signed [X_BITS-1:0]   x_next;
		logic [Y_BITS-1:0]          y_next;
		logic signed [ERR_BITS-1:0] err_next;
		logic                       done;
		logic signed [PIX_BITS-1:0] px_minus;
		logic signed [PIX_BITS-1:0] px_plus;
		logic signed [PIX_BITS-1:0] py_plus;
		logic signed [PIX_BITS-1:0] py_minus;
	} step_res_t;

endpackage

FILE: rtl/circle_outline_rasterizer.sv
// ----------------------------------------------------------------------------
// circle_outline_rasterizer
// Midpoint circle outline generator with stream ports and an APB register port.
// ----------------------------------------------------------------------------
// the first result is registered and offered in the cycle after the input transaction
// start and idle-step commands give one result and can be taken every cycle while the result port is not stalled
// a pixel step gives four results, one per result transaction, through the single result port
// the next input is taken in the cycle the last result of the previous one leaves
// reset (asynchronous, active low): frame 800 x 600, no circle active, no results
module circle_outline_rasterizer (
	input  logic        clk,
	input  logic        arst_n,
	// apb register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // center_x[11:0], center_y[23:12], radius[34:24], color[66:35]
	input  logic        s_tuser,   // cmd
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // pixel_x[13:0], pixel_y[27:14], pixel_color[59:28]
	output logic [2:0]  m_tuser,   // status[1:0], done_res[2]
	output logic        m_tlast    // last_of_step
);
	import cor_pkg::*;

	// configuration
	logic [FRAME_BITS-1:0] frame_w_q, frame_h_q;
	logic                  cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_w_q <= FRAME_W_RESET;
			frame_h_q <= FRAME_H_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_FRAME_W: frame_w_q <= pwdata[FRAME_BITS-1:0];
				REG_FRAME_H: frame_h_q <= pwdata[FRAME_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_FRAME_W: prdata = 32'(frame_w_q);
			REG_FRAME_H: prdata = 32'(frame_h_q);
			default:     prdata = '0;
		endcase
	end

	// input fields
	logic [COORD_BITS-1:0] in_cx, in_cy;
	logic [RAD_BITS-1:0]   in_rad;
	logic [COLOR_BITS-1:0] in_color;
	logic                  in_cmd;

	assign in_cx    = s_tdata[11:0];
	assign in_cy    = s_tdata[23:12];
	assign in_rad   = s_tdata[34:24];
	assign in_color = s_tdata[66:35];
	assign in_cmd   = s_tuser;

	// circle state
	logic                       active_q;
	logic [COORD_BITS-1:0]      center_col_q, center_row_q;
	logic signed [X_BITS-1:0]   step_x_q;
	logic [Y_BITS-1:0]          step_y_q;
	logic signed [ERR_BITS-1:0] err_q;
	logic [COLOR_BITS-1:0]      color_q;

	step_res_t step;

	cor_step u_step (
		.center_col (center_col_q),
		.center_row (center_row_q),
		.x          (step_x_q),
		.y          (step_y_q),
		.err        (err_q),
		.res        (step)
	);

	// result buffer, drained one result per transaction
	logic                       buf_valid_q;
	logic [1:0]                 idx_q, last_idx_q;
	logic [STATUS_BITS-1:0]     res_status_q;
	logic                       res_done_q;
	logic [COLOR_BITS-1:0]      res_color_q;
	logic signed [PIX_BITS-1:0] res_pxm_q, res_pxp_q, res_pyp_q, res_pym_q;

	logic in_fire, out_fire, out_final, reject;

	assign out_fire  = m_tvalid && m_tready;
	assign out_final = out_fire && (idx_q == last_idx_q);
	assign s_tready  = !buf_valid_q || out_final;
	assign in_fire   = s_tvalid && s_tready;
	assign reject    = ({1'b0, in_cx} >= frame_w_q) || ({1'b0, in_cy} >= frame_h_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q     <= 1'b0;
			center_col_q <= '0;
			center_row_q <= '0;
			step_x_q     <= '0;
			step_y_q     <= '0;
			err_q        <= '0;
			color_q      <= '0;
		end else if (in_fire) begin
			if (in_cmd == CMD_START) begin
				if (reject) begin
					active_q <= 1'b0;
				end else begin
					active_q     <= 1'b1;
					center_col_q <= in_cx;
					center_row_q <= in_cy;
					step_x_q     <= -$signed({2'b00, in_rad});
					step_y_q     <= '0;
					err_q        <= ERR_BITS'(2) - $signed({4'b0000, in_rad, 1'b0});
					color_q      <= in_color;
				end
			end else if (active_q) begin
				step_x_q <= step.x_next;
				step_y_q <= step.y_next;
				err_q    <= step.err_next;
				if (step.done) begin
					active_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_valid_q <= 1'b0;
			idx_q       <= '0;
			last_idx_q  <= '0;
		end else if (in_fire) begin
			buf_valid_q <= 1'b1;
			idx_q       <= '0;
			last_idx_q  <= (in_cmd == CMD_STEP && active_q) ? 2'd3 : 2'd0;
		end else if (out_final) begin
			buf_valid_q <= 1'b0;
		end else if (out_fire) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			res_done_q  <= 1'b0;
			res_color_q <= '0;
			res_pxm_q   <= '0;
			res_pxp_q   <= '0;
			res_pyp_q   <= '0;
			res_pym_q   <= '0;
			if (in_cmd == CMD_START) begin
				res_status_q <= reject ? STATUS_REJECTED : STATUS_STARTED;
			end else if (!active_q) begin
				res_status_q <= STATUS_IDLE;
			end else begin
				res_status_q <= STATUS_PIXEL;
				res_done_q   <= step.done;
				res_color_q  <= color_q;
				res_pxm_q    <= step.px_minus;
				res_pxp_q    <= step.px_plus;
				res_pyp_q    <= step.py_plus;
				res_pym_q    <= step.py_minus;
			end
		end
	end

	// mirror order: (-x,+y) (+x,+y) (+x,-y) (-x,-y)
	logic signed [PIX_BITS-1:0] out_px, out_py;

	always_comb begin
		case (idx_q)
			2'd0:    begin out_px = res_pxm_q; out_py = res_pyp_q; end
			2'd1:    begin out_px = res_pxp_q; out_py = res_pyp_q; end
			2'd2:    begin out_px = res_pxp_q; out_py = res_pym_q; end
			default: begin out_px = res_pxm_q; out_py = res_pym_q; end
		endcase
	end

	assign m_tvalid = buf_valid_q;
	assign m_tdata  = {4'b0000, res_color_q, out_py, out_px};
	assign m_tuser  = {res_done_q, res_status_q};
	assign m_tlast  = (idx_q == last_idx_q);

endmodule

FILE: rtl/cor_step.sv
// ----------------------------------------------------------------------------
// cor_step
// One midpoint circle iteration: mirrored pixel coordinates and next x, y, error.
// ----------------------------------------------------------------------------
module cor_step (
	input  logic [cor_pkg::COORD_BITS-1:0]    center_col,
	input  logic [cor_pkg::COORD_BITS-1:0]    center_row,
	input  logic signed [cor_pkg::X_BITS-1:0]   x,
	input  logic [cor_pkg::Y_BITS-1:0]          y,
	input  logic signed [cor_pkg::ERR_BITS-1:0] err,
	output cor_pkg::step_res_t                  res
);
	import cor_pkg::*;

	localparam int W = 18;

	logic signed [W-1:0] xe, ye, te, t, xn, yn, e;
	logic signed [PIX_BITS-1:0] cc, cr, xp, yp;

	assign xe = W'(x);
	assign ye = W'($signed({1'b0, y}));
	assign te = W'(err);

	always_comb begin
		t  = te;
		yn = ye;
		xn = xe;
		e  = te;
		if (t <= ye) begin
			yn = ye + W'(1);
			e  = e + (yn <<< 1) + W'(1);
			// tie case forces the x advance
			if ((-xe == yn) && (t <= xe)) begin
				t = '0;
			end
		end
		if (t > xe) begin
			xn = xe + W'(1);
			e  = e + (xn <<< 1) + W'(1);
		end
	end

	assign cc = $signed({2'b00, center_col});
	assign cr = $signed({2'b00, center_row});
	assign xp = PIX_BITS'(x);
	assign yp = $signed({2'b00, y});

	always_comb begin
		res          = '0;
		res.x_next   = xn[X_BITS-1:0];
		res.y_next   = yn[Y_BITS-1:0];
		res.err_next = e[ERR_BITS-1:0];
		res.done     = !xn[W-1] && (xn != '0);
		res.px_minus = cc - xp;
		res.px_plus  = cc + xp;
		res.py_plus  = cr + yp;
		res.py_minus = cr - yp;
	end

endmodule
